>>> sv/assert_macros.svh
// assertion macros used by the top classifier rtl file
// expects a clock i_clk and an active-low reset i_rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MMDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mmdc assertion failed");

// next-cycle implication
`define MMDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mmdc assertion failed");

`endif

>>> sv/mmdc_pkg.sv
// types and constants of the mahalanobis minimum distance classifier
// no dependencies
package mmdc_pkg;

    localparam int NUM_CLASSES  = 3;
    localparam int NUM_FEATURES = 4;
    localparam int IN_FEATS     = 4;

    localparam int FEAT_W   = 16;
    localparam int COEF_W   = 32;
    localparam int D_W      = FEAT_W + 1;
    localparam int P_W      = D_W + COEF_W;
    localparam int T_W      = P_W + 3;
    localparam int TL_W     = 32;
    localparam int TH_W     = T_W - TL_W;
    localparam int LO_W     = TL_W + 1 + D_W;
    localparam int HI_W     = TH_W + D_W;
    localparam int ACC_W    = T_W + D_W + 3;
    localparam int FRAC_SH  = 20;
    localparam int Q_W      = ACC_W - FRAC_SH;
    localparam int DIST_W   = 48;
    localparam int CLS_W    = $clog2(NUM_CLASSES);

    localparam logic [1:0] OP_LOAD_MEAN = 2'd0;
    localparam logic [1:0] OP_LOAD_COEF = 2'd1;
    localparam logic [1:0] OP_CLASSIFY  = 2'd2;

    typedef logic [IN_FEATS-1:0][FEAT_W-1:0] t_feats;

    typedef struct packed {
        logic [1:0]               op;
        logic [1:0]               class_sel;
        logic [1:0]               row;
        logic [1:0]               col;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [FEAT_W-1:0] feature_0;
        logic signed [FEAT_W-1:0] feature_1;
        logic signed [FEAT_W-1:0] feature_2;
        logic signed [FEAT_W-1:0] feature_3;
        logic [1:0]               expected_class;
    } t_item;

    typedef struct packed {
        logic [1:0]               best_class;
        logic signed [DIST_W-1:0] best_distance;
        logic                     mismatch;
    } t_result;

    // per-lane table write
    typedef struct packed {
        logic              we_mean;
        logic              we_coef;
        logic [1:0]        row;
        logic [1:0]        col;
        logic [COEF_W-1:0] coef;
        t_feats            feat;
    } t_lane_wr;

endpackage

>>> sv/mmdc_ifs.sv
// valid/ready channel interfaces for items and results
// depends on mmdc_pkg
interface mmdc_item_if import mmdc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmdc_res_if import mmdc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/mahalanobis_min_distance_classifier_core.sv
// Minimum Mahalanobis distance classifier. One lane per class holds that class's
// mean and inverse covariance in registers and evaluates d^T C d exactly; a merge
// stage picks the smallest. Loads write the tables at the accepting beat and give no
// result; a classify beat's result passes through the input register, the four lane
// stages and the output register. One beat is taken every cycle; the whole pipeline
// holds only while the output register has a beat that is not taken.
// Tables reset to zero.
// depends on mmdc_pkg, mmdc_ifs, mmdc_lane, mmdc_merge, mmdc_core, assert_macros.svh
`include "assert_macros.svh"

module mahalanobis_min_distance_classifier_core import mmdc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mmdc_item_if.sink  i_item,
    mmdc_res_if.source o_res
);

    logic     en;
    logic     acc;
    t_item    it;
    t_lane_wr wr [NUM_CLASSES];

    logic         r_v0;
    t_feats       r_x0;
    logic [1:0]   r_e0;

    logic signed [ACC_W-1:0] total [NUM_CLASSES];
    logic [CLS_W-1:0]         best;
    logic signed [DIST_W-1:0] best_dist;
    logic                     v4;
    logic [1:0]               e4;

    logic    r_out_valid;
    t_result r_out;
    logic [1:0] r_out_exp;

    assign it  = i_item.data;
    assign en  = !r_out_valid || o_res.ready;
    assign acc = i_item.valid && en;
    assign i_item.ready = en;

    for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lane
        assign wr[c].we_mean = acc && it.op == OP_LOAD_MEAN && 32'(it.class_sel) == c;
        assign wr[c].we_coef = acc && it.op == OP_LOAD_COEF && 32'(it.class_sel) == c;
        assign wr[c].row     = it.row;
        assign wr[c].col     = it.col;
        assign wr[c].coef    = it.coef_value;
        assign wr[c].feat    = {it.feature_3, it.feature_2, it.feature_1, it.feature_0};

        mmdc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_wr    (wr[c]),
            .i_x     (r_x0),
            .o_total (total[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= acc && it.op == OP_CLASSIFY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0 <= {it.feature_3, it.feature_2, it.feature_1, it.feature_0};
            r_e0 <= it.expected_class;
        end
    end

    mmdc_core u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_start (r_v0),
        .i_exp   (r_e0),
        .o_valid (v4),
        .o_exp   (e4)
    );

    mmdc_merge u_merge (
        .i_total (total),
        .o_best  (best),
        .o_dist  (best_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.best_class    <= 2'(best);
            r_out.best_distance <= best_dist;
            r_out.mismatch      <= (CLS_W + 2)'(best) != (CLS_W + 2)'(e4);
            r_out_exp           <= e4;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    `MMDC_ASSERT_IMP(a_stall_blocks_input, r_out_valid && !o_res.ready, !i_item.ready)
    `MMDC_ASSERT_NEXT(a_classify_enters, acc && it.op == OP_CLASSIFY, r_v0)
    `MMDC_ASSERT_IMP(a_mismatch_flag, r_out_valid && NUM_CLASSES <= 4,
        r_out.mismatch == (r_out.best_class != r_out_exp))

endmodule

>>> sv/mmdc_lane.sv
// one class lane: holds mean and inverse covariance, computes d^T C d exactly
// depends on mmdc_pkg
module mmdc_lane import mmdc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_lane_wr                i_wr,
    input  t_feats                  i_x,
    output logic signed [ACC_W-1:0] o_total
);

    logic signed [FEAT_W-1:0] r_mean [NUM_FEATURES];
    logic signed [COEF_W-1:0] r_coef [NUM_FEATURES][NUM_FEATURES];
    logic signed [FEAT_W-1:0] x_ext  [NUM_FEATURES];

    logic signed [D_W-1:0]  n_d  [NUM_FEATURES];
    logic signed [D_W-1:0]  r_d1 [NUM_FEATURES];
    logic signed [D_W-1:0]  r_d2 [NUM_FEATURES];
    logic signed [P_W-1:0]  r_p  [NUM_FEATURES][NUM_FEATURES];
    logic signed [T_W-1:0]  n_t  [NUM_FEATURES];
    logic signed [T_W-1:0]  r_t  [NUM_FEATURES];
    logic signed [LO_W-1:0] r_lo [NUM_FEATURES];
    logic signed [HI_W-1:0] r_hi [NUM_FEATURES];
    logic signed [ACC_W-1:0] n_total;
    logic signed [ACC_W-1:0] r_total;

    for (genvar k = 0; k < NUM_FEATURES; k++) begin : g_mean
        if (k < IN_FEATS) begin : g_in
            assign x_ext[k] = $signed(i_x[k]);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mean[k] <= '0;
                end else if (i_wr.we_mean) begin
                    r_mean[k] <= $signed(i_wr.feat[k]);
                end
            end
        end else begin : g_pad
            // features past the input width read as zero and are never loaded
            assign x_ext[k] = '0;
            always_ff @(posedge i_clk) begin
                r_mean[k] <= '0;
            end
        end
        for (genvar j = 0; j < NUM_FEATURES; j++) begin : g_coef
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_coef[k][j] <= '0;
                end else if (i_wr.we_coef && 32'(i_wr.row) == k && 32'(i_wr.col) == j) begin
                    r_coef[k][j] <= $signed(i_wr.coef);
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_FEATURES; k++) begin
            n_d[k] = D_W'(x_ext[k]) - D_W'(r_mean[k]);
        end
    end

    // stage 1: d and the d[k] * c[k][j] products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_FEATURES; k++) begin
                r_d1[k] <= n_d[k];
                for (int j = 0; j < NUM_FEATURES; j++) begin
                    r_p[k][j] <= P_W'(n_d[k]) * P_W'(r_coef[k][j]);
                end
            end
        end
    end

    // stage 2: column sums t[j]
    always_comb begin
        for (int j = 0; j < NUM_FEATURES; j++) begin
            n_t[j] = '0;
            for (int k = 0; k < NUM_FEATURES; k++) begin
                n_t[j] = n_t[j] + T_W'(r_p[k][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t  <= n_t;
            r_d2 <= r_d1;
        end
    end

    // stage 3: t[j] * d[j] split into low and high halves of t
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NUM_FEATURES; j++) begin
                r_lo[j] <= LO_W'($signed({1'b0, r_t[j][TL_W-1:0]})) * LO_W'(r_d2[j]);
                r_hi[j] <= HI_W'($signed(r_t[j][T_W-1:TL_W])) * HI_W'(r_d2[j]);
            end
        end
    end

    // stage 4: exact q36.36 total
    always_comb begin
        n_total = '0;
        for (int j = 0; j < NUM_FEATURES; j++) begin
            n_total = n_total + (ACC_W'(r_hi[j]) <<< TL_W) + ACC_W'(r_lo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_total <= n_total;
        end
    end

    assign o_total = r_total;

endmodule

>>> sv/mmdc_merge.sv
// merges lane distances: signed minimum, lowest index on ties, q32.16 saturation
// depends on mmdc_pkg
module mmdc_merge import mmdc_pkg::*; (
    input  logic signed [ACC_W-1:0]  i_total [NUM_CLASSES],
    output logic [CLS_W-1:0]         o_best,
    output logic signed [DIST_W-1:0] o_dist
);

    logic signed [ACC_W-1:0] best_tot;
    logic signed [Q_W-1:0]   q;

    always_comb begin
        best_tot = i_total[0];
        o_best   = '0;
        for (int c = 1; c < NUM_CLASSES; c++) begin
            if (i_total[c] < best_tot) begin
                best_tot = i_total[c];
                o_best   = CLS_W'(c);
            end
        end
    end

    // floor to q32.16, then clamp to the 48-bit range
    assign q = Q_W'(best_tot >>> FRAC_SH);

    always_comb begin
        if (q[Q_W-1:DIST_W-1] == '0 || q[Q_W-1:DIST_W-1] == '1) begin
            o_dist = q[DIST_W-1:0];
        end else if (q[Q_W-1]) begin
            o_dist = {1'b1, {(DIST_W-1){1'b0}}};
        end else begin
            o_dist = {1'b0, {(DIST_W-1){1'b1}}};
        end
    end

endmodule

>>> sv/mmdc_core.sv
// stage valid and expected label pipeline of the classifier
// depends on mmdc_pkg
module mmdc_core import mmdc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_start,
    input  logic [1:0] i_exp,
    output logic       o_valid,
    output logic [1:0] o_exp
);

    // valid and expected label follow the four lane stages
    logic [3:0]       r_v;
    logic [3:0][1:0]  r_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e <= {r_e[2:0], i_exp};
        end
    end

    assign o_valid = r_v[3];
    assign o_exp   = r_e[3];

endmodule

>>> tb/mmdc_scoreboard.sv
// scoreboard for the mahalanobis minimum distance classifier: predicts results from items
// depends on mmdc_pkg
`timescale 1ns / 100ps

package mmdc_tb_pkg;
    import mmdc_pkg::*;

    class mmdc_scoreboard;
        logic signed [15:0] means [NUM_CLASSES][NUM_FEATURES];
        logic signed [31:0] icov [NUM_CLASSES][NUM_FEATURES][NUM_FEATURES];
        t_result pending_results[$];
        int n_errors;
        int n_checked;
        int n_classify;
        int n_loads;

        function new();
            foreach (means[c, j]) means[c][j] = '0;
            foreach (icov[c, r, k]) icov[c][r][k] = '0;
            n_errors = 0;
            n_checked = 0;
            n_classify = 0;
            n_loads = 0;
        endfunction

        // exact quadratic form d^T C d in Q36.36
        function logic signed [127:0] quad_form(int c, logic signed [15:0] x [NUM_FEATURES]);
            logic signed [127:0] d [NUM_FEATURES];
            logic signed [127:0] t;
            logic signed [127:0] acc;
            acc = '0;
            for (int j = 0; j < NUM_FEATURES; j++)
                d[j] = 128'(x[j]) - 128'(means[c][j]);
            for (int j = 0; j < NUM_FEATURES; j++) begin
                t = '0;
                for (int k = 0; k < NUM_FEATURES; k++)
                    t += d[k] * 128'(icov[c][k][j]);
                acc += t * d[j];
            end
            return acc;
        endfunction

        function void note_item(t_item it);
            logic signed [15:0] x [NUM_FEATURES];
            logic signed [127:0] best_q, q;
            int best;
            t_result res;
            case (it.op)
                OP_LOAD_MEAN: begin
                    n_loads++;
                    if (it.class_sel < NUM_CLASSES) begin
                        means[it.class_sel][0] = it.feature_0;
                        means[it.class_sel][1] = it.feature_1;
                        means[it.class_sel][2] = it.feature_2;
                        means[it.class_sel][3] = it.feature_3;
                    end
                end
                OP_LOAD_COEF: begin
                    n_loads++;
                    if (it.class_sel < NUM_CLASSES)
                        icov[it.class_sel][it.row][it.col] = it.coef_value;
                end
                OP_CLASSIFY: begin
                    n_classify++;
                    x[0] = it.feature_0;
                    x[1] = it.feature_1;
                    x[2] = it.feature_2;
                    x[3] = it.feature_3;
                    best = 0;
                    best_q = quad_form(0, x);
                    for (int c = 1; c < NUM_CLASSES; c++) begin
                        q = quad_form(c, x);
                        if (q < best_q) begin
                            best_q = q;
                            best = c;
                        end
                    end
                    // floor to q32.16 then saturate
                    best_q = best_q >>> 20;
                    if (best_q > 128'sh7FFF_FFFF_FFFF)
                        best_q = 128'sh7FFF_FFFF_FFFF;
                    if (best_q < -128'sh8000_0000_0000)
                        best_q = -128'sh8000_0000_0000;
                    res.best_class = best[1:0];
                    res.best_distance = best_q[47:0];
                    res.mismatch = (best[1:0] != it.expected_class);
                    pending_results.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: class %0d distance %0d", got.best_class,
                       got.best_distance);
                n_errors++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (got.best_class !== want.best_class) begin
                $error("best_class: expected %0d actual %0d", want.best_class, got.best_class);
                n_errors++;
            end
            if (got.best_distance !== want.best_distance) begin
                $error("best_distance: expected %0d actual %0d", want.best_distance,
                       got.best_distance);
                n_errors++;
            end
            if (got.mismatch !== want.mismatch) begin
                $error("mismatch: expected %0d actual %0d", want.mismatch, got.mismatch);
                n_errors++;
            end
        endfunction
    endclass
endpackage

>>> tb/tb.sv
// top of the classifier testbench: drives items, stalls results, checks via the scoreboard
// depends on mmdc_pkg, mmdc_ifs, mmdc_tb_pkg and the classifier core
`timescale 1ns / 100ps

module tb;
    import mmdc_pkg::*;
    import mmdc_tb_pkg::*;

    localparam int LATENCY = 5;

    logic i_clk;
    logic i_rst_n;
    int stall_mode;

    mmdc_item_if item_ch ();
    mmdc_res_if  res_ch ();

    mahalanobis_min_distance_classifier_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_res   (res_ch.source)
    );

    mmdc_scoreboard sb = new();

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [15:0] rand_feat();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item make_item(logic [1:0] op);
        t_item it;
        it.op = op;
        it.class_sel = 2'($urandom);
        it.row = 2'($urandom);
        it.col = 2'($urandom);
        it.coef_value = rand_coef();
        it.feature_0 = rand_feat();
        it.feature_1 = rand_feat();
        it.feature_2 = rand_feat();
        it.feature_3 = rand_feat();
        it.expected_class = 2'($urandom);
        return it;
    endfunction

    // hold one item on the channel until it is taken
    task automatic send_item(t_item it);
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic send_idle(int n);
        item_ch.valid <= 1'b0;
        item_ch.data <= t_item'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // result side: accept on valid and ready at each edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.data);
    end

    // receiver stall pattern changes over the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                2: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default: res_ch.ready <= ($urandom_range(0, 15) < 8);
            endcase
        end
    end

    initial begin
        #(5_000_000ns);
        $display("mahalanobis_min_distance_classifier_core regression: fail");
        $finish;
    end

    initial begin
        t_item it;
        int burst;
        stall_mode = 0;
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        res_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: classify on reset tables, then extremes and ignored loads
        it = make_item(OP_CLASSIFY);
        it.expected_class = 2'd0;
        send_item(it);
        it.expected_class = 2'd3;
        send_item(it);
        for (int c = 0; c < 4; c++) begin
            it = make_item(OP_LOAD_MEAN);
            it.class_sel = 2'(c);
            it.feature_0 = 16'h8000;
            it.feature_1 = 16'h7FFF;
            send_item(it);
        end
        for (int k = 0; k < 4; k++) begin
            it = make_item(OP_LOAD_COEF);
            it.class_sel = 2'(k);
            it.row = 2'(k);
            it.col = 2'(k);
            it.coef_value = (k == 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            send_item(it);
        end
        it = make_item(2'd3);
        send_item(it);
        for (int k = 0; k < 4; k++) begin
            it = make_item(OP_CLASSIFY);
            it.feature_0 = (k[0]) ? 16'h7FFF : 16'h8000;
            it.feature_1 = (k[1]) ? 16'h7FFF : 16'h8000;
            it.feature_2 = 16'h7FFF;
            it.feature_3 = 16'h8000;
            it.expected_class = 2'(k);
            send_item(it);
        end

        // pause until every pending result is out
        wait_drained();

        // random: a mix of mean and coefficient loads and classifies, some noise
        for (int n = 0; n < 1000; n += burst) begin
            stall_mode = $urandom_range(0, 3);
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++) begin
                case ($urandom_range(0, 9))
                    0, 1: it = make_item(OP_LOAD_MEAN);
                    2, 3: it = make_item(OP_LOAD_COEF);
                    4: it = make_item(2'd3);
                    default: it = make_item(OP_CLASSIFY);
                endcase
                // near a class mean now and then so ties and close calls occur
                if (it.op == OP_CLASSIFY && $urandom_range(0, 3) == 0) begin
                    it.feature_0 = sb.means[it.class_sel % NUM_CLASSES][0]
                                   + 16'($urandom_range(0, 3));
                    it.feature_1 = sb.means[it.class_sel % NUM_CLASSES][1];
                end
                send_item(it);
            end
            if ($urandom_range(0, 2) != 0)
                send_idle($urandom_range(1, 12));
        end

        item_ch.valid <= 1'b0;
        stall_mode = 1;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY * 4) @(posedge i_clk);

        $display("covered %0d classify and %0d load beats, %0d results compared",
                 sb.n_classify, sb.n_loads, sb.n_checked);
        if (sb.n_errors == 0) begin
            $display("mahalanobis_min_distance_classifier_core regression: pass");
        end else begin
            $display("mahalanobis_min_distance_classifier_core regression: fail");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+sv
sv/mmdc_pkg.sv
sv/mmdc_ifs.sv
sv/mmdc_lane.sv
sv/mmdc_merge.sv
sv/mmdc_core.sv
sv/mahalanobis_min_distance_classifier_core.sv
tb/mmdc_scoreboard.sv
tb/tb.sv
